[rtl/uer_pkg.sv]
`default_nettype none

package uer_pkg;

   // speed of sound term: 331300 + 606 * temperature, always positive for an 8-bit temperature
   localparam int SPEED_BITS = 19;
   localparam int SPEED_CALC_BITS = 20;
   localparam logic signed [SPEED_CALC_BITS-1:0] SPEED_BASE = 20'sd331300;
   localparam logic signed [SPEED_CALC_BITS-1:0] SPEED_SLOPE = 20'sd606;

   // distance = product / 200000, remainder always below the divisor
   localparam int REM_BITS = 18;
   localparam logic [REM_BITS:0] DIVISOR = 19'd200000;

   localparam int DIST_BITS = 17;
   localparam logic [DIST_BITS-1:0] DIST_MAX = 17'd131071;
   localparam logic [DIST_BITS-1:0] CM_TO_CENTI = 17'd100;

   localparam int TICK_BITS = 4;
   localparam int WAIT_BITS = 16;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam int TEMP_BITS = 8;
   localparam int RANGE_BITS = 10;

   localparam logic [WAIT_BITS-1:0] TIMEOUT_RESET = 16'd30000;
   localparam logic signed [TEMP_BITS-1:0] TEMP_RESET = 8'sd20;
   localparam logic [RANGE_BITS-1:0] RANGE_RESET = 10'd400;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TIMEOUT = 2'd0,
      CSR_TEMP    = 2'd1,
      CSR_RANGE   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_TIMEOUT = 2'd1,
      ST_RANGE   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      P_IDLE  = 3'd0,
      P_PRE   = 3'd1,
      P_TRIG  = 3'd2,
      P_WAIT  = 3'd3,
      P_COUNT = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      C_IDLE = 2'd0,
      C_MUL  = 2'd1,
      C_DIV  = 2'd2,
      C_FIN  = 2'd3
   } ctl_type;

endpackage

`default_nettype wire

[rtl/ultrasonic_echo_ranger.sv]
// a tick that ends an echo gets its distance from the bit-serial multiply followed by
//    the bit-serial divide by 200000
// throughput: one tick item per cycle while req_stall is low, one item in flight at a time
// reset: synchronous, active high; phase goes idle, counters clear, registers
//    take timeout 30000, temperature 20 and max range 400
`default_nettype none

module ultrasonic_echo_ranger #(
   parameter int PRE_LOW_TICKS = 2,
   parameter int TRIG_TICKS = 10,
   parameter int ECHO_COUNT_BITS = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    csr_we,
   input  wire logic [uer_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  wire logic [uer_pkg::CSR_DATA_BITS-1:0]       csr_wdata,
   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic                                    req_start_req,
   input  wire logic                                    req_echo_level,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic                                         rsp_trigger_level,
   output logic                                         rsp_busy_res,
   output logic                                         rsp_done_res,
   output logic [1:0]                                   rsp_status,
   output logic [uer_pkg::DIST_BITS-1:0]                rsp_distance_centi_cm
);

   localparam int PW = ECHO_COUNT_BITS + uer_pkg::SPEED_BITS;
   localparam int STEP_BITS = $clog2(PW + 1);
   localparam logic [ECHO_COUNT_BITS-1:0] COUNT_MAX = '1;

   // configuration
   logic [uer_pkg::WAIT_BITS-1:0]         timeout_ff;
   logic signed [uer_pkg::TEMP_BITS-1:0]  temperature_ff;
   logic [uer_pkg::RANGE_BITS-1:0]        max_range_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= uer_pkg::TIMEOUT_RESET;
         temperature_ff <= uer_pkg::TEMP_RESET;
         max_range_ff <= uer_pkg::RANGE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            uer_pkg::CSR_TIMEOUT: timeout_ff <= csr_wdata;
            uer_pkg::CSR_TEMP:    temperature_ff <= csr_wdata[uer_pkg::TEMP_BITS-1:0];
            uer_pkg::CSR_RANGE:   max_range_ff <= csr_wdata[uer_pkg::RANGE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // measurement state
   uer_pkg::phase_type                    phase_ff, phase_in, eff_phase;
   logic [uer_pkg::TICK_BITS-1:0]         phase_ticks_ff, phase_ticks_in, eff_ticks, tick_inc;
   logic [uer_pkg::WAIT_BITS-1:0]         wait_ff, wait_in;
   logic [ECHO_COUNT_BITS-1:0]            echo_ff, echo_in;

   // arithmetic datapath
   uer_pkg::ctl_type                      ctl_ff, ctl_in;
   logic [STEP_BITS-1:0]                  step_ff, step_in;
   logic [uer_pkg::SPEED_BITS-1:0]        speed_ff, speed_in;
   logic [ECHO_COUNT_BITS-1:0]            cnt_sh_ff, cnt_sh_in;
   logic [PW-1:0]                         acc_ff, acc_in;
   logic [uer_pkg::REM_BITS-1:0]          rem_ff, rem_in;
   logic [uer_pkg::DIST_BITS-1:0]         quo_ff, quo_in;
   logic                                  ovf_ff, ovf_in;

   logic signed [uer_pkg::SPEED_CALC_BITS-1:0] speed_full;
   logic [uer_pkg::REM_BITS:0]            rem_cat;
   logic                                  rem_ge;
   logic [uer_pkg::DIST_BITS-1:0]         range_lim;

   // per-tick result
   logic                                  t_trig, t_busy, t_done, launch;
   uer_pkg::status_type                   t_status;

   // output register
   logic                                  rsp_valid_ff;
   logic                                  rsp_trig_ff, rsp_busy_ff, rsp_done_ff;
   logic [1:0]                            rsp_status_ff;
   logic [uer_pkg::DIST_BITS-1:0]         rsp_dist_ff;

   logic                                  req_take, rsp_load_tick, fin_load;
   logic [1:0]                            fin_status;
   logic [uer_pkg::DIST_BITS-1:0]         fin_dist;

   assign req_stall = (ctl_ff != uer_pkg::C_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_take = req_valid && !req_stall;

   // one tick of the ranging sequence
   always_comb begin
      eff_phase = phase_ff;
      eff_ticks = phase_ticks_ff;
      t_busy = 1'b1;
      if (phase_ff == uer_pkg::P_IDLE) begin
         if (req_start_req) begin
            eff_phase = uer_pkg::P_PRE;
            eff_ticks = '0;
         end else begin
            t_busy = 1'b0;
         end
      end
      tick_inc = eff_ticks + 4'd1;
      phase_in = eff_phase;
      phase_ticks_in = eff_ticks;
      wait_in = wait_ff;
      echo_in = echo_ff;
      t_trig = 1'b0;
      t_done = 1'b0;
      t_status = uer_pkg::ST_OK;
      launch = 1'b0;
      unique case (eff_phase)
         uer_pkg::P_IDLE: ;
         uer_pkg::P_PRE: begin
            phase_ticks_in = tick_inc;
            if (tick_inc >= uer_pkg::TICK_BITS'(PRE_LOW_TICKS)) begin
               phase_in = uer_pkg::P_TRIG;
               phase_ticks_in = '0;
            end
         end
         uer_pkg::P_TRIG: begin
            t_trig = 1'b1;
            phase_ticks_in = tick_inc;
            if (tick_inc >= uer_pkg::TICK_BITS'(TRIG_TICKS)) begin
               phase_in = uer_pkg::P_WAIT;
               phase_ticks_in = '0;
               wait_in = '0;
            end
         end
         uer_pkg::P_WAIT: begin
            if (req_echo_level) begin
               phase_in = uer_pkg::P_COUNT;
               echo_in = ECHO_COUNT_BITS'(1);
            end else if (wait_ff >= timeout_ff) begin
               t_busy = 1'b0;
               t_done = 1'b1;
               t_status = uer_pkg::ST_TIMEOUT;
               phase_in = uer_pkg::P_IDLE;
               phase_ticks_in = '0;
            end else begin
               wait_in = wait_ff + 16'd1;
            end
         end
         uer_pkg::P_COUNT: begin
            if (req_echo_level) begin
               if (echo_ff != COUNT_MAX) begin
                  echo_in = echo_ff + ECHO_COUNT_BITS'(1);
               end
            end else begin
               // falling edge: distance comes from the serial datapath
               launch = 1'b1;
               phase_in = uer_pkg::P_IDLE;
               phase_ticks_in = '0;
            end
         end
         default: begin
            t_busy = 1'b0;
            phase_in = uer_pkg::P_IDLE;
            phase_ticks_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= uer_pkg::P_IDLE;
         phase_ticks_ff <= '0;
         wait_ff <= '0;
         echo_ff <= '0;
      end else if (req_take) begin
         phase_ff <= phase_in;
         phase_ticks_ff <= phase_ticks_in;
         wait_ff <= wait_in;
         echo_ff <= echo_in;
      end
   end

   assign speed_full = uer_pkg::SPEED_BASE
      + uer_pkg::SPEED_CALC_BITS'(temperature_ff) * uer_pkg::SPEED_SLOPE;

   assign rem_cat = {rem_ff, acc_ff[PW-1]};
   assign rem_ge = rem_cat >= uer_pkg::DIVISOR;
   assign range_lim = uer_pkg::DIST_BITS'(max_range_ff) * uer_pkg::CM_TO_CENTI;

   // shift-add multiply, then restoring divide, one bit per cycle
   always_comb begin
      ctl_in = ctl_ff;
      step_in = step_ff;
      speed_in = speed_ff;
      cnt_sh_in = cnt_sh_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      ovf_in = ovf_ff;
      fin_load = 1'b0;
      fin_dist = ovf_ff ? uer_pkg::DIST_MAX : quo_ff;
      fin_status = uer_pkg::ST_OK;
      if (ovf_ff || quo_ff == '0 || quo_ff >= range_lim) begin
         fin_status = uer_pkg::ST_RANGE;
      end
      unique case (ctl_ff)
         uer_pkg::C_IDLE: begin
            if (req_take && launch) begin
               ctl_in = uer_pkg::C_MUL;
               step_in = '0;
               speed_in = speed_full[uer_pkg::SPEED_BITS-1:0];
               cnt_sh_in = echo_ff;
               acc_in = '0;
            end
         end
         uer_pkg::C_MUL: begin
            acc_in = (acc_ff << 1) + (cnt_sh_ff[ECHO_COUNT_BITS-1] ? PW'(speed_ff) : '0);
            cnt_sh_in = cnt_sh_ff << 1;
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(ECHO_COUNT_BITS - 1)) begin
               ctl_in = uer_pkg::C_DIV;
               step_in = '0;
               rem_in = '0;
               quo_in = '0;
               ovf_in = 1'b0;
            end
         end
         uer_pkg::C_DIV: begin
            acc_in = acc_ff << 1;
            rem_in = rem_ge ? uer_pkg::REM_BITS'(rem_cat - uer_pkg::DIVISOR)
                            : rem_cat[uer_pkg::REM_BITS-1:0];
            quo_in = {quo_ff[uer_pkg::DIST_BITS-2:0], rem_ge};
            ovf_in = ovf_ff | quo_ff[uer_pkg::DIST_BITS-1];
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(PW - 1)) begin
               ctl_in = uer_pkg::C_FIN;
            end
         end
         uer_pkg::C_FIN: begin
            fin_load = 1'b1;
            ctl_in = uer_pkg::C_IDLE;
         end
         default: ctl_in = uer_pkg::C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= uer_pkg::C_IDLE;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      speed_ff <= speed_in;
      cnt_sh_ff <= cnt_sh_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   assign rsp_load_tick = req_take && !launch;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load_tick || fin_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load_tick) begin
         rsp_trig_ff <= t_trig;
         rsp_busy_ff <= t_busy;
         rsp_done_ff <= t_done;
         rsp_status_ff <= t_status;
         rsp_dist_ff <= '0;
      end else if (fin_load) begin
         rsp_trig_ff <= 1'b0;
         rsp_busy_ff <= 1'b0;
         rsp_done_ff <= 1'b1;
         rsp_status_ff <= fin_status;
         rsp_dist_ff <= fin_dist;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_trigger_level = rsp_trig_ff;
   assign rsp_busy_res = rsp_busy_ff;
   assign rsp_done_res = rsp_done_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_distance_centi_cm = rsp_dist_ff;

endmodule

`default_nettype wire

[rtl/uer_checker.sv]
`default_nettype none

module uer_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic                          rsp_trigger_level,
   input wire logic                          rsp_busy_res,
   input wire logic                          rsp_done_res,
   input wire logic [1:0]                    rsp_status,
   input wire logic [uer_pkg::DIST_BITS-1:0] rsp_distance_centi_cm
);

   // a finished measurement is never also busy or triggering
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res && !rsp_trigger_level)
      else $error("done item shows busy or trigger");

   // status and distance only carry data on the done item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> rsp_status == uer_pkg::ST_OK
         && rsp_distance_centi_cm == '0)
      else $error("status or distance without done");

   // a timeout never reports a distance
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == uer_pkg::ST_TIMEOUT |-> rsp_distance_centi_cm == '0)
      else $error("timeout with nonzero distance");

   // the trigger is only driven inside a measurement
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_trigger_level |-> rsp_busy_res)
      else $error("trigger high while not busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_distance_centi_cm)
         && $stable(rsp_status))
      else $error("stalled item changed");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_trigger_level     (rsp_trigger_level),
   .rsp_busy_res          (rsp_busy_res),
   .rsp_done_res          (rsp_done_res),
   .rsp_status            (rsp_status),
   .rsp_distance_centi_cm (rsp_distance_centi_cm)
);

`default_nettype wire
